@@ src/mrpt_pkg.sv @@
// package: widths and witness bases of the primality tester
package mrpt_pkg;

	localparam int NUMBER_WIDTH = 63;
	localparam int BASE_COUNT   = 12;
	localparam int BASE_IDX_W   = $clog2(BASE_COUNT);
	localparam int BIT_IDX_W    = $clog2(NUMBER_WIDTH + 1);

	typedef logic [NUMBER_WIDTH-1:0] num_t;

	// witness base for each index
	function automatic num_t witness_base(input logic [BASE_IDX_W-1:0] idx);
		num_t b;
		case (idx)
			4'd0:    b = num_t'(2);
			4'd1:    b = num_t'(3);
			4'd2:    b = num_t'(5);
			4'd3:    b = num_t'(7);
			4'd4:    b = num_t'(11);
			4'd5:    b = num_t'(13);
			4'd6:    b = num_t'(17);
			4'd7:    b = num_t'(19);
			4'd8:    b = num_t'(23);
			4'd9:    b = num_t'(29);
			4'd10:   b = num_t'(31);
			4'd11:   b = num_t'(37);
			default: b = num_t'(2);
		endcase
		return b;
	endfunction

endpackage

@@ src/mrpt_mulmod.sv @@
// modular multiplier, one bit of the multiplier operand per cycle
module mrpt_mulmod (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  mrpt_pkg::num_t a,
	input  mrpt_pkg::num_t b,
	input  mrpt_pkg::num_t n,
	output logic           done,
	output mrpt_pkg::num_t r
);
	import mrpt_pkg::*;

	logic [BIT_IDX_W-1:0] cnt_q;
	logic                 busy_q;
	num_t                 a_q, b_q, r_q;
	logic [NUMBER_WIDTH:0] dbl, dbl_red, add, add_red;
	num_t                 r_next;

	// one step: r = 2r mod n, then add a if the top bit of b is set
	always_comb begin
		dbl     = {r_q, 1'b0};
		dbl_red = (dbl >= {1'b0, n}) ? dbl - {1'b0, n} : dbl;
		add     = dbl_red + {1'b0, a_q};
		add_red = (add >= {1'b0, n}) ? add - {1'b0, n} : add;
		r_next  = b_q[NUMBER_WIDTH-1] ? add_red[NUMBER_WIDTH-1:0]
		                              : dbl_red[NUMBER_WIDTH-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= BIT_IDX_W'(NUMBER_WIDTH);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == BIT_IDX_W'(1)) busy_q <= 1'b0;
		end
	end

	// operand and accumulator shift registers
	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			r_q <= '0;
		end else if (busy_q) begin
			r_q <= r_next;
			b_q <= {b_q[NUMBER_WIDTH-2:0], 1'b0};
		end
	end

	assign done = busy_q && (cnt_q == BIT_IDX_W'(1));
	assign r    = r_next;
endmodule

@@ src/miller_rabin_prime_test.sv @@
// top level: deterministic miller-rabin test over twelve witness bases
//  channel | signals                          | beat
//  input   | candidate_valid/_ready/candidate | one number below 2^63
//  output  | is_prime_valid/_ready/is_prime   | one prime flag
// one item at a time; a modular multiply loads its operands, then takes one bit
// of the 63-bit operand a cycle, and per base there are at most about 126
// multiplies, since the bits of d and the s-1 squarings share the 63 bits of
// n-1, all done on the shared bit-serial multiplier. reset returns to idle;
// the result holds in its output register until taken, and the next
// candidate waits until then.
module miller_rabin_prime_test (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              candidate_valid,
	output logic                              candidate_ready,
	input  logic [mrpt_pkg::NUMBER_WIDTH-1:0] candidate,
	output logic                              is_prime_valid,
	input  logic                              is_prime_ready,
	output logic                              is_prime
);
	import mrpt_pkg::*;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_SPLIT = 4'd1;
	localparam logic [3:0] ST_BASE  = 4'd2;
	localparam logic [3:0] ST_RED   = 4'd3;
	localparam logic [3:0] ST_EXP   = 4'd4;
	localparam logic [3:0] ST_MUL   = 4'd5;
	localparam logic [3:0] ST_SQB   = 4'd6;
	localparam logic [3:0] ST_CHK   = 4'd7;
	localparam logic [3:0] ST_SQX   = 4'd8;
	localparam logic [3:0] ST_OUT   = 4'd9;

	logic [3:0]           state_q;
	num_t                 n_q, d_q, e_q, res_q, bb_q;
	logic [BIT_IDX_W-1:0] s_q, r_q;
	logic [BASE_IDX_W-1:0] k_q;
	logic                 prime_q;
	logic                 mm_start, mm_done;
	num_t                 mm_a, mm_b, mm_r, nm1;
	logic                 sel_sq_q;

	assign nm1 = n_q - 1'b1;
	assign candidate_ready = (state_q == ST_IDLE);
	assign is_prime_valid  = (state_q == ST_OUT);
	assign is_prime        = prime_q;

	mrpt_mulmod u_mul (
		.clk(clk), .arst_n(arst_n), .start(mm_start),
		.a(mm_a), .b(mm_b), .n(n_q), .done(mm_done), .r(mm_r)
	);

	// multiplier operands: result*base, base*base or res*res
	always_comb begin
		mm_a = sel_sq_q ? bb_q : res_q;
		mm_b = bb_q;
		if (state_q == ST_SQX) begin
			mm_a = res_q;
			mm_b = res_q;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			mm_start <= 1'b0;
			sel_sq_q <= 1'b0;
			n_q      <= '0;
			d_q      <= '0;
			e_q      <= '0;
			res_q    <= '0;
			bb_q     <= '0;
			s_q      <= '0;
			r_q      <= '0;
			k_q      <= '0;
			prime_q  <= 1'b0;
		end else begin
			mm_start <= 1'b0;
			case (state_q)
				ST_IDLE: if (candidate_valid) begin
					n_q     <= candidate;
					d_q     <= candidate - 1'b1;
					s_q     <= '0;
					k_q     <= '0;
					prime_q <= 1'b0;
					state_q <= ST_SPLIT;
					if (candidate < num_t'(2)) state_q <= ST_OUT;
				end
				// strip trailing zeros of n-1, one bit a cycle
				ST_SPLIT: begin
					if (n_q[0] == 1'b1 && d_q[0] == 1'b0) begin
						d_q <= d_q >> 1;
						s_q <= s_q + 1'b1;
					end else begin
						state_q <= ST_BASE;
					end
				end
				// prime base match, else load base for reduction
				ST_BASE: begin
					if (n_q == witness_base(k_q)) begin
						prime_q <= 1'b1;
						state_q <= ST_OUT;
					end else begin
						bb_q    <= witness_base(k_q);
						state_q <= ST_RED;
					end
				end
				// base mod n, base is at most 37 so a few subtractions
				ST_RED: begin
					if (bb_q >= n_q) bb_q <= bb_q - n_q;
					else begin
						e_q     <= d_q;
						res_q   <= num_t'(1);
						state_q <= ST_EXP;
					end
				end
				ST_EXP: begin
					if (e_q == '0) begin
						r_q     <= BIT_IDX_W'(1);
						state_q <= ST_CHK;
					end else if (e_q[0]) begin
						sel_sq_q <= 1'b0;
						mm_start <= 1'b1;
						state_q  <= ST_MUL;
					end else begin
						sel_sq_q <= 1'b1;
						mm_start <= 1'b1;
						state_q  <= ST_SQB;
					end
				end
				ST_MUL: if (mm_done) begin
					res_q    <= mm_r;
					sel_sq_q <= 1'b1;
					mm_start <= 1'b1;
					state_q  <= ST_SQB;
				end
				ST_SQB: if (mm_done) begin
					bb_q    <= mm_r;
					e_q     <= e_q >> 1;
					state_q <= ST_EXP;
				end
				// pass test, another squaring, or composite
				ST_CHK: begin
					if (res_q == num_t'(1) || res_q == nm1) begin
						if (k_q == BASE_IDX_W'(BASE_COUNT - 1)) begin
							prime_q <= 1'b1;
							state_q <= ST_OUT;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= ST_BASE;
						end
					end else if (r_q < s_q) begin
						mm_start <= 1'b1;
						state_q  <= ST_SQX;
					end else begin
						prime_q <= 1'b0;
						state_q <= ST_OUT;
					end
				end
				// after a squaring only n-1 passes; 1 means composite
				ST_SQX: if (mm_done) begin
					r_q <= r_q + 1'b1;
					if (mm_r == nm1) begin
						res_q   <= nm1;
						state_q <= ST_CHK;
					end else if (mm_r == num_t'(1)) begin
						prime_q <= 1'b0;
						state_q <= ST_OUT;
					end else begin
						res_q   <= mm_r;
						state_q <= ST_CHK;
					end
				end
				ST_OUT: if (is_prime_ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

@@ tb/tb_miller_rabin_prime_test.sv @@
// testbench: primality verdicts of miller_rabin_prime_test checked against a local predictor
`timescale 1ns / 1ps

module tb_miller_rabin_prime_test;
	import mrpt_pkg::*;

	localparam int WATCHDOG_LIMIT = 1000000;
	localparam int LONG_HOLD      = 3000;
	localparam int RANDOM_ITEMS   = 350;

	typedef struct {
		num_t number;
		bit   drain_first;
	} pending_t;

	logic clk;
	logic arst_n;
	logic candidate_valid;
	logic candidate_ready;
	num_t candidate;
	logic is_prime_valid;
	logic is_prime_ready;
	logic is_prime;

	pending_t pending_q[$];
	bit       verdict_q[$];
	int       errors;
	int       primes_seen;
	int       composites_seen;
	int       idle_cycles;
	bit       stimulus_done;

	miller_rabin_prime_test i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.candidate_valid (candidate_valid),
		.candidate_ready (candidate_ready),
		.candidate       (candidate),
		.is_prime_valid  (is_prime_valid),
		.is_prime_ready  (is_prime_ready),
		.is_prime        (is_prime)
	);

	// clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// (a * b) mod n with a double-width product
	function automatic logic [63:0] mulmod(logic [63:0] a, logic [63:0] b, logic [63:0] n);
		logic [127:0] p;
		p = a * b;
		return 64'(p % n);
	endfunction

	function automatic logic [63:0] powmod(logic [63:0] b, logic [63:0] e, logic [63:0] n);
		logic [63:0] acc;
		logic [63:0] sq;
		acc = 64'd1 % n;
		sq  = b % n;
		while (e != 0) begin
			if (e[0])
				acc = mulmod(acc, sq, n);
			sq = mulmod(sq, sq, n);
			e  = e >> 1;
		end
		return acc;
	endfunction

	// deterministic strong-probable-prime test over the twelve bases
	function automatic bit predict_prime(num_t value);
		logic [63:0] n;
		logic [63:0] d;
		logic [63:0] x;
		int          s;
		bit          ok;
		n = 64'(value);
		if (n < 2)
			return 1'b0;
		for (int k = 0; k < BASE_COUNT; k++)
			if (n == 64'(witness_base(BASE_IDX_W'(k))))
				return 1'b1;
		d = n - 1;
		s = 0;
		while (d[0] == 1'b0 && s < 64) begin
			d = d >> 1;
			s++;
		end
		for (int k = 0; k < BASE_COUNT; k++) begin
			x  = powmod(64'(witness_base(BASE_IDX_W'(k))), d, n);
			ok = (x == 1) || (x == n - 1);
			for (int r = 1; r < s && !ok; r++) begin
				x = mulmod(x, x, n);
				if (x == n - 1)
					ok = 1'b1;
			end
			if (!ok)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic num_t rand_num();
		return num_t'({$urandom(), $urandom()});
	endfunction

	function automatic int rand_gap();
		int r;
		r = $urandom_range(99);
		if (r < 65)
			return 0;
		else if (r < 93)
			return $urandom_range(5, 1);
		return $urandom_range(300, 20);
	endfunction

	function automatic void push_item(num_t v, bit drain);
		pending_t p;
		p.number      = v;
		p.drain_first = drain;
		pending_q.insert(pending_q.size(), p);
	endfunction

	// stimulus
	initial begin
		num_t v;
		int   kind;
		errors          = 0;
		primes_seen     = 0;
		composites_seen = 0;
		stimulus_done   = 0;
		arst_n          = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// below two, witness bases, small evens, a small prime, odd composites
		push_item(num_t'(0), 0);
		push_item(num_t'(1), 0);
		push_item(num_t'(2), 0);
		push_item(num_t'(3), 0);
		push_item(num_t'(4), 0);
		push_item(num_t'(37), 0);
		push_item(num_t'(36), 0);
		push_item(num_t'(41), 0);
		push_item(num_t'(39), 0);
		push_item(num_t'(25), 0);
		push_item(num_t'(49), 0);
		// carmichael, strong pseudoprimes to the first bases and a prime
		push_item(num_t'(561), 0);
		push_item(num_t'(1373653), 0);
		push_item(num_t'(64'd3215031751), 0);
		push_item(num_t'(64'd1000000007), 0);
		// extremes: all ones, largest prime below 2^63, mersenne prime
		push_item(num_t'(64'h7fffffffffffffff), 0);
		push_item(num_t'(64'd9223372036854775783), 0);
		push_item(num_t'(64'd2305843009213693951), 0);
		// sender pause until all verdicts are back
		push_item(num_t'(64'h4000000000000000), 1);
		push_item(num_t'(64'h7ffffffffffffffe), 0);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			kind = $urandom_range(99);
			if (kind < 30)
				v = rand_num();
			else if (kind < 50)
				v = num_t'($urandom_range(5000));
			else if (kind < 75)
				v = rand_num() | num_t'(1);
			else begin
				// search an odd prime so that all twelve bases run
				do
					v = (rand_num() >> $urandom_range(40)) | num_t'(1);
				while (!predict_prime(v));
			end
			push_item(v, (i == RANDOM_ITEMS / 2));
		end
		stimulus_done = 1;
	end

	// driver
	int   send_gap;
	logic next_valid;
	num_t next_number;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			candidate_valid <= 1'b0;
			candidate       <= '0;
			send_gap        = 0;
		end else begin
			next_valid  = candidate_valid;
			next_number = candidate;
			if (candidate_valid && candidate_ready) begin
				verdict_q.insert(verdict_q.size(), predict_prime(candidate));
				void'(pending_q.pop_front());
				next_valid = 1'b0;
				send_gap   = rand_gap();
			end
			if (!next_valid) begin
				if (send_gap > 0)
					send_gap--;
				else if (pending_q.size() > 0 &&
						(!pending_q[0].drain_first || verdict_q.size() == 0)) begin
					next_valid  = 1'b1;
					next_number = pending_q[0].number;
				end
			end
			candidate_valid <= next_valid;
			candidate       <= next_number;
		end
	end

	// monitor: random ready, one long hold after a few beats
	int  recv_gap;
	int  beats_taken;
	bit  hold_done;
	logic next_ready;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			is_prime_ready <= 1'b0;
			recv_gap       = 0;
			beats_taken    = 0;
			hold_done      = 0;
		end else begin
			next_ready = is_prime_ready;
			if (is_prime_valid && is_prime_ready) begin
				beats_taken++;
				if (verdict_q.size() == 0) begin
					$display("%0t: unexpected beat, expected none, actual is_prime=%0b",
						$time, is_prime);
					errors++;
				end else begin
					if (is_prime !== verdict_q[0]) begin
						$display("%0t: is_prime mismatch, expected %0b, actual %0b",
							$time, verdict_q[0], is_prime);
						errors++;
					end
					if (verdict_q[0])
						primes_seen++;
					else
						composites_seen++;
					void'(verdict_q.pop_front());
				end
				if (beats_taken == 5 && !hold_done) begin
					recv_gap  = LONG_HOLD;
					hold_done = 1;
				end else
					recv_gap = rand_gap();
				next_ready = (recv_gap == 0);
			end else if (!is_prime_ready) begin
				if (recv_gap > 0)
					recv_gap--;
				next_ready = (recv_gap == 0);
			end
			is_prime_ready <= next_ready;
		end
	end

	// watchdog on cycles without any accepted beat
	always @(posedge clk) begin
		if (!arst_n || (candidate_valid && candidate_ready) ||
				(is_prime_valid && is_prime_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog expired, %0d verdicts outstanding",
				$time, verdict_q.size());
			$display("Mismatches found");
			$finish;
		end
	end

	// end of run
	initial begin
		wait (stimulus_done);
		while (pending_q.size() != 0 || verdict_q.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		$display("checked %0d verdicts: %0d prime, %0d composite",
			primes_seen + composites_seen, primes_seen, composites_seen);
		$display("covered witness bases, evens, pseudoprimes, 63-bit extremes and stalls");
		if (errors == 0 && verdict_q.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
